/* src/esrs_pkg.sv */
// Shared types and constants for the EDF/RMS tick scheduler.
// No dependencies; used by every module of the block.
package esrs_pkg;

    localparam int MAX_TASKS   = 8;
    localparam int SLOT_W      = $clog2(MAX_TASKS);
    localparam int CNT_W       = 4;
    localparam int LABEL_W     = 8;
    localparam int TIME_W      = 12;
    localparam int JOB_W       = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    // queue depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic MODE_EDF = 1'b0;
    localparam logic MODE_RMS = 1'b1;

    // register select is paddr bit 2
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic [JOB_W-1:0] FIRST_JOB = JOB_W'(1);

    typedef struct packed {
        logic               func;
        logic [SLOT_W-1:0]  slot;
        logic [LABEL_W-1:0] label;
        logic [TIME_W-1:0]  compute_time;
        logic [TIME_W-1:0]  period;
    } item_t;

    typedef struct packed {
        logic             mode;
        logic [CNT_W-1:0] task_count;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               idle;
        logic [SLOT_W-1:0]  run_slot;
        logic [LABEL_W-1:0] run_label;
        logic [JOB_W-1:0]   invocation;
        logic               job_done;
        logic [TIME_W-1:0]  job_length;
    } result_t;

endpackage

/* src/esrs_regs.sv */
// APB configuration registers: scheduling mode and task count.
// Depends on esrs_pkg.
module esrs_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [esrs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [esrs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [esrs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output esrs_pkg::cfg_t                   cfg
);

    logic                         mode_reg;
    logic                         mode_next;
    logic [esrs_pkg::CNT_W-1:0]   count_reg;
    logic [esrs_pkg::CNT_W-1:0]   count_next;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            case (paddr[2])
                esrs_pkg::REG_MODE:  mode_next  = pwdata[0];
                esrs_pkg::REG_COUNT: count_next = pwdata[esrs_pkg::CNT_W-1:0];
                default:             mode_next  = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= esrs_pkg::MODE_EDF;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            esrs_pkg::REG_MODE:  prdata = esrs_pkg::APB_DATA_W'(mode_reg);
            esrs_pkg::REG_COUNT: prdata = esrs_pkg::APB_DATA_W'(count_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.mode       = mode_reg;
    assign cfg.task_count = count_reg;

endmodule

/* src/esrs_front.sv */
// Front end: takes command words and holds them in a short queue.
// Depends on esrs_pkg.
module esrs_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  esrs_pkg::item_t      in_item,
    output logic                 busy,
    input  logic                 pop,
    output logic                 q_valid,
    output esrs_pkg::item_t      q_item
);

    esrs_pkg::item_t                 queue_reg [esrs_pkg::QUEUE_DEPTH];
    logic [esrs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [esrs_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [esrs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [esrs_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [esrs_pkg::QCNT_W-1:0]     cnt_reg;
    logic [esrs_pkg::QCNT_W-1:0]     cnt_next;
    logic                            push;
    logic                            pull;

    assign busy    = (cnt_reg == esrs_pkg::QCNT_W'(esrs_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign pull    = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pull ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pull)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pull && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* src/esrs_engine.sv */
// Back end: task tables, pick search, job update and period countdown sweep.
// Depends on esrs_pkg.
module esrs_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  esrs_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  esrs_pkg::item_t      q_item,
    output logic                 pop,
    output esrs_pkg::result_t    result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC,
        S_SWEEP
    } state_t;

    localparam int SW = esrs_pkg::SLOT_W;
    localparam int CW = esrs_pkg::CNT_W;
    localparam int TW = esrs_pkg::TIME_W;
    localparam int N  = esrs_pkg::MAX_TASKS;

    // task tables, no reset: contents are defined once a slot is loaded
    logic [esrs_pkg::LABEL_W-1:0] label_mem   [N];
    logic [TW-1:0]                cstore_mem  [N];
    logic [TW-1:0]                pstore_mem  [N];
    logic [TW-1:0]                cleft_mem   [N];
    logic [TW-1:0]                pleft_mem   [N];
    logic [esrs_pkg::JOB_W-1:0]   job_mem     [N];

    state_t              state_reg;
    state_t              state_next;
    logic [N-1:0]        active_reg;
    logic [N-1:0]        active_next;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       idx_next;
    logic [SW-1:0]       pick_reg;
    logic [SW-1:0]       pick_next;
    logic                found_reg;
    logic                found_next;
    logic [TW-1:0]       best_reg;
    logic [TW-1:0]       best_next;
    logic                cur_valid_reg;
    logic                cur_valid_next;
    logic [SW-1:0]       cur_reg;
    logic [SW-1:0]       cur_next;
    esrs_pkg::result_t   result_reg;
    esrs_pkg::result_t   result_next;

    logic [CW-1:0]       used;
    logic [CW-1:0]       idx_inc;
    logic [SW-1:0]       rd_idx;
    logic [TW-1:0]       key;
    logic [TW-1:0]       cl_dec;
    logic                cl_zero;
    logic [TW-1:0]       pl_dec;
    logic                keep_cur;
    logic                do_load;
    logic                do_exec;
    logic                do_sweep;

    assign used    = (cfg.task_count > CW'(N)) ? CW'(N) : cfg.task_count;
    assign idx_inc = idx_reg + 1'b1;
    assign rd_idx  = (state_reg == S_EXEC) ? pick_reg : idx_reg[SW-1:0];
    assign key     = (cfg.mode == esrs_pkg::MODE_EDF) ? pleft_mem[rd_idx] : pstore_mem[rd_idx];
    // compute left saturates at zero
    assign cl_dec  = (cleft_mem[rd_idx] != '0) ? cleft_mem[rd_idx] - 1'b1 : '0;
    assign cl_zero = (cl_dec == '0);
    assign pl_dec  = pleft_mem[rd_idx] - 1'b1;
    assign keep_cur = (cfg.mode == esrs_pkg::MODE_RMS) && cur_valid_reg
                      && (CW'(cur_reg) < used) && active_reg[cur_reg];

    assign pop      = (state_reg == S_IDLE);
    assign do_load  = pop && q_valid && (q_item.func == esrs_pkg::FUNC_LOAD);
    assign do_exec  = (state_reg == S_EXEC) && found_reg;
    assign do_sweep = (state_reg == S_SWEEP);

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        pick_next      = pick_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        result_next    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.func == esrs_pkg::FUNC_LOAD)
                    begin
                        active_next[q_item.slot] = 1'b1;
                    end
                    else if (keep_cur)
                    begin
                        pick_next  = cur_reg;
                        found_next = 1'b1;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        idx_next   = '0;
                        state_next = (used == '0) ? S_EXEC : S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // ties keep the lower slot
                if (active_reg[rd_idx] && (!found_reg || key < best_reg))
                begin
                    best_next  = key;
                    pick_next  = rd_idx;
                    found_next = 1'b1;
                end
                idx_next = idx_inc;
                if (idx_inc == used)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                result_next.valid = 1'b1;
                result_next.idle  = !found_reg;
                if (found_reg)
                begin
                    result_next.run_slot   = pick_reg;
                    result_next.run_label  = label_mem[rd_idx];
                    result_next.invocation = job_mem[rd_idx];
                    if (cl_zero)
                    begin
                        active_next[rd_idx]    = 1'b0;
                        result_next.job_done   = 1'b1;
                        result_next.job_length = cstore_mem[rd_idx];
                    end
                end
                cur_valid_next = found_reg;
                cur_next       = found_reg ? pick_reg : '0;
                idx_next       = '0;
                state_next     = (used == '0) ? S_IDLE : S_SWEEP;
            end

            S_SWEEP:
            begin
                if (pl_dec == '0)
                begin
                    active_next[rd_idx] = 1'b1;
                end
                idx_next = idx_inc;
                if (idx_inc == used)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            idx_reg       <= '0;
            pick_reg      <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            cur_valid_reg <= 1'b0;
            cur_reg       <= '0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            pick_reg      <= pick_next;
            found_reg     <= found_next;
            best_reg      <= best_next;
            cur_valid_reg <= cur_valid_next;
            cur_reg       <= cur_next;
            result_reg    <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            label_mem[q_item.slot]  <= q_item.label;
            cstore_mem[q_item.slot] <= q_item.compute_time;
            pstore_mem[q_item.slot] <= q_item.period;
            cleft_mem[q_item.slot]  <= q_item.compute_time;
            pleft_mem[q_item.slot]  <= q_item.period;
            job_mem[q_item.slot]    <= esrs_pkg::FIRST_JOB;
        end
        if (do_exec)
        begin
            cleft_mem[rd_idx] <= cl_dec;
            if (cl_zero)
            begin
                job_mem[rd_idx] <= job_mem[rd_idx] + 1'b1;
            end
        end
        if (do_sweep)
        begin
            // reload period and work when the period runs out
            if (pl_dec == '0)
            begin
                pleft_mem[rd_idx] <= pstore_mem[rd_idx];
                cleft_mem[rd_idx] <= cstore_mem[rd_idx];
            end
            else
            begin
                pleft_mem[rd_idx] <= pl_dec;
            end
        end
    end

    assign result = result_reg;

endmodule

/* src/edf_rms_tick_scheduler_core.sv */
// Channel   | Handshake                         | Word
// ----------+-----------------------------------+---------------------------------------------
// command   | start & !busy                     | func, slot, label, compute_time, period
// result    | valid (one cycle, no back-press.) | idle, run_slot, run_label, invocation,
//           |                                   | job_done, job_length
// config    | APB psel & penable & pwrite       | pwdata at 4*i: mode, task_count
//
// A load is taken while the engine is idle. A tick steps the engine through dispatch,
// N search steps, the job update and N countdown steps, N = min(task_count, 8);
// a kept rate monotonic task skips the search. The single port per task table
// sets this. The result word is registered and appears in the cycle after the job update.
// A two-word command queue lets start be taken while a tick is in progress; busy
// rises only when the queue is full. Reset clears the active flags and the current task.
// Top level: ties the APB registers, command queue and scheduling engine together.
// Depends on esrs_pkg, esrs_regs, esrs_front, esrs_engine.
module edf_rms_tick_scheduler_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 func,
    input  logic [esrs_pkg::SLOT_W-1:0]          slot,
    input  logic [esrs_pkg::LABEL_W-1:0]         label,
    input  logic [esrs_pkg::TIME_W-1:0]          compute_time,
    input  logic [esrs_pkg::TIME_W-1:0]          period,
    output logic                                 valid,
    output logic                                 idle,
    output logic [esrs_pkg::SLOT_W-1:0]          run_slot,
    output logic [esrs_pkg::LABEL_W-1:0]         run_label,
    output logic [esrs_pkg::JOB_W-1:0]           invocation,
    output logic                                 job_done,
    output logic [esrs_pkg::TIME_W-1:0]          job_length,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [esrs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [esrs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [esrs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    esrs_pkg::cfg_t      cfg;
    esrs_pkg::item_t     in_item;
    esrs_pkg::item_t     q_item;
    esrs_pkg::result_t   result;
    logic                q_valid;
    logic                pop;

    assign in_item.func         = func;
    assign in_item.slot         = slot;
    assign in_item.label        = label;
    assign in_item.compute_time = compute_time;
    assign in_item.period       = period;

    esrs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esrs_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .busy    (busy),
        .pop     (pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    esrs_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .result  (result)
    );

    assign valid      = result.valid;
    assign idle       = result.idle;
    assign run_slot   = result.run_slot;
    assign run_label  = result.run_label;
    assign invocation = result.invocation;
    assign job_done   = result.job_done;
    assign job_length = result.job_length;

endmodule

/* src/esrs_checker.sv */
// Port-level checks for the scheduler core, bound to the top level.
// Depends on esrs_pkg and edf_rms_tick_scheduler_core.
module esrs_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             valid,
    input  logic                             idle,
    input  logic [esrs_pkg::SLOT_W-1:0]      run_slot,
    input  logic [esrs_pkg::LABEL_W-1:0]     run_label,
    input  logic [esrs_pkg::JOB_W-1:0]       invocation,
    input  logic                             job_done,
    input  logic [esrs_pkg::TIME_W-1:0]      job_length,
    input  logic                             pready
);

    // an idle tick carries an all-zero word
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && idle |-> run_slot == '0 && run_label == '0 && invocation == '0
                          && job_done == 1'b0 && job_length == '0)
        else $error("idle result with nonzero fields");

    a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !job_done |-> job_length == '0)
        else $error("job length reported without completion");

    // each tick spends at least dispatch and update cycles in the engine
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result words in consecutive cycles");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind edf_rms_tick_scheduler_core esrs_checker u_esrs_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (valid),
    .idle       (idle),
    .run_slot   (run_slot),
    .run_label  (run_label),
    .invocation (invocation),
    .job_done   (job_done),
    .job_length (job_length),
    .pready     (pready)
);

/* bench/edf_rms_tick_scheduler_core_tb.sv */
// Self-checking bench for edf_rms_tick_scheduler_core: drives load and tick words,
// predicts each tick's result word and checks the words as they arrive.
// Depends on esrs_pkg and the RTL of the scheduler core.
module edf_rms_tick_scheduler_core_tb;

    // two queued ticks plus one in the engine, at eight slots each
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_WORDS   = 140;
    localparam int RANDOM_PHASES = 12;
    localparam int BURST_TICKS   = 20;

    class sched_scoreboard;
        bit [esrs_pkg::LABEL_W-1:0] label_of [esrs_pkg::MAX_TASKS];
        bit [esrs_pkg::TIME_W-1:0]  work_len [esrs_pkg::MAX_TASKS];
        bit [esrs_pkg::TIME_W-1:0]  work_left [esrs_pkg::MAX_TASKS];
        bit [esrs_pkg::TIME_W-1:0]  period_len [esrs_pkg::MAX_TASKS];
        bit [esrs_pkg::TIME_W-1:0]  period_left [esrs_pkg::MAX_TASKS];
        bit                         runnable [esrs_pkg::MAX_TASKS];
        bit [esrs_pkg::JOB_W-1:0]   job_no [esrs_pkg::MAX_TASKS];
        bit                         has_current;
        int                         current_slot;
        bit                         mode;
        bit [esrs_pkg::CNT_W-1:0]   count;
        esrs_pkg::result_t          pending_runs[$];
        int                         mismatches;
        int                         words_checked;
        int                         idle_ticks;
        int                         finished_jobs;
        int                         loads;

        task report_mismatch(input string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        function void note_command(input esrs_pkg::item_t c);
            esrs_pkg::result_t r;
            int used;
            int pick;
            int best;
            int key;
            used = (count > esrs_pkg::MAX_TASKS) ? esrs_pkg::MAX_TASKS : count;
            if (c.func == esrs_pkg::FUNC_LOAD) begin
                label_of[c.slot]    = c.label;
                work_len[c.slot]    = c.compute_time;
                work_left[c.slot]   = c.compute_time;
                period_len[c.slot]  = c.period;
                period_left[c.slot] = c.period;
                runnable[c.slot]    = 1'b1;
                job_no[c.slot]      = esrs_pkg::FIRST_JOB;
                loads++;
                return;
            end
            r = '0;
            r.valid = 1'b1;
            r.idle = 1'b1;
            pick = -1;
            // keep the running task under rate monotonic while it still has work
            if (mode == esrs_pkg::MODE_RMS && has_current && current_slot < used
                && runnable[current_slot])
                pick = current_slot;
            else begin
                best = 1 << esrs_pkg::TIME_W;
                for (int j = 0; j < used; j++) begin
                    key = (mode == esrs_pkg::MODE_EDF) ? period_left[j] : period_len[j];
                    if (runnable[j] && key < best) begin
                        best = key;
                        pick = j;
                    end
                end
            end
            if (pick >= 0) begin
                r.idle       = 1'b0;
                r.run_slot   = esrs_pkg::SLOT_W'(pick);
                r.run_label  = label_of[pick];
                r.invocation = job_no[pick];
                // a job with no work left finishes at once
                if (work_left[pick] != 0)
                    work_left[pick]--;
                if (work_left[pick] == 0) begin
                    runnable[pick] = 1'b0;
                    r.job_done     = 1'b1;
                    r.job_length   = work_len[pick];
                    job_no[pick]++;
                    finished_jobs++;
                end
                has_current  = 1'b1;
                current_slot = pick;
            end
            else begin
                has_current  = 1'b0;
                current_slot = 0;
                idle_ticks++;
            end
            for (int j = 0; j < used; j++) begin
                period_left[j]--;
                if (period_left[j] == 0) begin
                    period_left[j] = period_len[j];
                    work_left[j]   = work_len[j];
                    runnable[j]    = 1'b1;
                end
            end
            pending_runs.push_back(r);
        endfunction

        task check_result(input esrs_pkg::result_t got);
            esrs_pkg::result_t want;
            if (pending_runs.size() == 0) begin
                report_mismatch("result word with no tick waiting");
                return;
            end
            want = pending_runs.pop_front();
            words_checked++;
            if (got.idle !== want.idle)
                report_mismatch($sformatf("word %0d idle: got %0b, want %0b",
                                          words_checked, got.idle, want.idle));
            if (got.run_slot !== want.run_slot)
                report_mismatch($sformatf("word %0d run_slot: got %0d, want %0d",
                                          words_checked, got.run_slot, want.run_slot));
            if (got.run_label !== want.run_label)
                report_mismatch($sformatf("word %0d run_label: got %0h, want %0h",
                                          words_checked, got.run_label, want.run_label));
            if (got.invocation !== want.invocation)
                report_mismatch($sformatf("word %0d invocation: got %0d, want %0d",
                                          words_checked, got.invocation, want.invocation));
            if (got.job_done !== want.job_done)
                report_mismatch($sformatf("word %0d job_done: got %0b, want %0b",
                                          words_checked, got.job_done, want.job_done));
            if (got.job_length !== want.job_length)
                report_mismatch($sformatf("word %0d job_length: got %0d, want %0d",
                                          words_checked, got.job_length, want.job_length));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic                            func;
    logic [esrs_pkg::SLOT_W-1:0]     slot;
    logic [esrs_pkg::LABEL_W-1:0]    label;
    logic [esrs_pkg::TIME_W-1:0]     compute_time;
    logic [esrs_pkg::TIME_W-1:0]     period;
    logic                            valid;
    logic                            idle;
    logic [esrs_pkg::SLOT_W-1:0]     run_slot;
    logic [esrs_pkg::LABEL_W-1:0]    run_label;
    logic [esrs_pkg::JOB_W-1:0]      invocation;
    logic                            job_done;
    logic [esrs_pkg::TIME_W-1:0]     job_length;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [esrs_pkg::APB_ADDR_W-1:0] paddr;
    logic [esrs_pkg::APB_DATA_W-1:0] pwdata;
    logic [esrs_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    sched_scoreboard board;
    bit [esrs_pkg::MAX_TASKS-1:0] loaded;
    int reg_writes;

    edf_rms_tick_scheduler_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .slot         (slot),
        .label        (label),
        .compute_time (compute_time),
        .period       (period),
        .valid        (valid),
        .idle         (idle),
        .run_slot     (run_slot),
        .run_label    (run_label),
        .invocation   (invocation),
        .job_done     (job_done),
        .job_length   (job_length),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        esrs_pkg::result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && valid === 1'b1) begin
                got            = '0;
                got.valid      = 1'b1;
                got.idle       = idle;
                got.run_slot   = run_slot;
                got.run_label  = run_label;
                got.invocation = invocation;
                got.job_done   = job_done;
                got.job_length = job_length;
                board.check_result(got);
            end
        end
    end

    function automatic esrs_pkg::item_t load_word(input int s, input int lbl, input int ct,
                                                  input int per);
        esrs_pkg::item_t c;
        c.func         = esrs_pkg::FUNC_LOAD;
        c.slot         = esrs_pkg::SLOT_W'(s);
        c.label        = esrs_pkg::LABEL_W'(lbl);
        c.compute_time = esrs_pkg::TIME_W'(ct);
        c.period       = esrs_pkg::TIME_W'(per);
        return c;
    endfunction

    function automatic esrs_pkg::item_t tick_word();
        esrs_pkg::item_t c;
        // fields other than func are don't-care for a tick; randomize them
        c.func         = esrs_pkg::FUNC_TICK;
        c.slot         = esrs_pkg::SLOT_W'($urandom);
        c.label        = esrs_pkg::LABEL_W'($urandom);
        c.compute_time = esrs_pkg::TIME_W'($urandom);
        c.period       = esrs_pkg::TIME_W'($urandom);
        return c;
    endfunction

    function automatic esrs_pkg::item_t next_random_item();
        esrs_pkg::item_t c;
        int used;
        int gap_slot;
        used = (board.count > esrs_pkg::MAX_TASKS) ? esrs_pkg::MAX_TASKS : board.count;
        gap_slot = -1;
        for (int j = used - 1; j >= 0; j--)
            if (!loaded[j])
                gap_slot = j;
        c = tick_word();
        // never tick with an unloaded slot in use: load it first
        if (gap_slot >= 0) begin
            c.func = esrs_pkg::FUNC_LOAD;
            c.slot = esrs_pkg::SLOT_W'(gap_slot);
        end
        else if ($urandom_range(0, 99) < 15) begin
            c.func = esrs_pkg::FUNC_LOAD;
            if (used > 0 && $urandom_range(0, 9) < 7)
                c.slot = esrs_pkg::SLOT_W'($urandom_range(0, used - 1));
        end
        if (c.func == esrs_pkg::FUNC_LOAD) begin
            case ($urandom_range(0, 9))
                0:       c.compute_time = '0;
                1:       c.compute_time = '1;
                2:       c.compute_time = esrs_pkg::TIME_W'($urandom);
                default: c.compute_time = esrs_pkg::TIME_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       c.period = esrs_pkg::TIME_W'($urandom_range(0, 1));
                1:       c.period = '1;
                2:       c.period = esrs_pkg::TIME_W'($urandom);
                default: c.period = esrs_pkg::TIME_W'($urandom_range(1, 30));
            endcase
        end
        return c;
    endfunction

    task automatic send_command(input esrs_pkg::item_t c);
        start        <= 1'b1;
        func         <= c.func;
        slot         <= c.slot;
        label        <= c.label;
        compute_time <= c.compute_time;
        period       <= c.period;
        forever
        begin
            @(posedge clk);
            if (busy === 1'b0)
                break;
        end
        if (c.func == esrs_pkg::FUNC_LOAD)
            loaded[c.slot] = 1'b1;
        board.note_command(c);
        @(negedge clk);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [esrs_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == esrs_pkg::REG_MODE)
            board.mode = data[0];
        else
            board.count = data[esrs_pkg::CNT_W-1:0];
        reg_writes++;
        @(negedge clk);
    endtask

    // drain the queue and the engine before touching the registers
    task automatic set_config(input logic m, input int n);
        start <= 1'b0;
        while (board.pending_runs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(esrs_pkg::REG_MODE, esrs_pkg::APB_DATA_W'(m));
        write_reg(esrs_pkg::REG_COUNT, esrs_pkg::APB_DATA_W'(n[esrs_pkg::CNT_W-1:0]));
    endtask

    initial
    begin
        bit quiet;
        int n;
        logic m;
        int k;
        board        = new();
        loaded       = '0;
        reg_writes   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = esrs_pkg::FUNC_TICK;
        slot         = '0;
        label        = '0;
        compute_time = '0;
        period       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no slots in use yet: the tick is idle and loads are stored for later
        send_command(tick_word());
        send_command(load_word(0, 8'h00, 0, 3));
        send_command(load_word(1, 8'hff, 4095, 4095));
        send_command(load_word(2, 8'h81, 1, 0));
        send_command(load_word(3, 8'h3c, 2, 1));
        send_command(load_word(4, 8'hc3, 4095, 2));
        send_command(load_word(5, 8'h5a, 3, 7));
        send_command(load_word(6, 8'ha5, 1, 4094));
        send_command(load_word(7, 8'h7e, 4095, 1));

        set_config(esrs_pkg::MODE_EDF, esrs_pkg::MAX_TASKS);
        repeat (5) send_command(tick_word());

        // oversized task count acts as all slots
        set_config(esrs_pkg::MODE_RMS, 15);
        repeat (5) send_command(tick_word());

        // shrink the slot range under the current task so it goes stale
        set_config(esrs_pkg::MODE_RMS, 1);
        repeat (3) send_command(tick_word());

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       begin m = esrs_pkg::MODE_EDF; n = esrs_pkg::MAX_TASKS; end
                1:       begin m = esrs_pkg::MODE_RMS; n = 0; end
                2:       begin m = esrs_pkg::MODE_RMS; n = 15; end
                3:       begin m = esrs_pkg::MODE_EDF; n = 1; end
                default: begin m = logic'($urandom_range(0, 1)); n = $urandom_range(0, 15); end
            endcase
            set_config(m, n);
            quiet = (phase >= RANDOM_PHASES - 2) || ($urandom_range(0, 3) == 0);

            // run one task back to back so its job number advances every tick
            if (phase == RANDOM_PHASES - 2) begin
                set_config(esrs_pkg::MODE_EDF, 1);
                send_command(load_word(0, 8'h99, 1, 1));
                repeat (BURST_TICKS) send_command(tick_word());
                set_config(m, n);
            end

            repeat (PHASE_WORDS)
            begin
                if (!quiet && $urandom_range(0, 5) == 0)
                    hold_off($urandom_range(1, 18));
                send_command(next_random_item());
            end
        end

        start <= 1'b0;
        for (k = 0; k < 20000 && board.pending_runs.size() != 0; k++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (board.pending_runs.size() != 0)
            board.report_mismatch($sformatf("%0d tick results never arrived",
                                            board.pending_runs.size()));

        $display("Checked %0d result words: %0d idle ticks, %0d finished jobs.",
                 board.words_checked, board.idle_ticks, board.finished_jobs);
        $display("Drove %0d loads and %0d register writes over both modes, counts 0 to 15.",
                 board.loads, reg_writes);
        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
